// ----- design/rsbk_pkg.sv -----
// Shared types and constants for the record sorter.
package rsbk_pkg;

    localparam int KEY_W = 32;
    localparam int TAG_W = 16;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } record_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_PLACE,
        ST_EMIT_RD,
        ST_EMIT_LD
    } state_t;

endpackage

// ----- design/rsbk_ram.sv -----
// Single-port-write, single-port-read record store with registered read data.
module rsbk_ram
    import rsbk_pkg::*;
#(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  record_t           wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output record_t           rd_data
);

    record_t mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read-before-write on a shared address
    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- design/record_sort_by_key.sv -----
// Top level of the record sorter: stable ascending sort of a set of records by key.
//
//  channel | direction | ports                                         | transaction
//  --------+-----------+-----------------------------------------------+--------------------------
//  s_      | in        | s_sort_key, s_record_tag, s_last_item         | one record of the set
//  m_      | out       | m_sorted_key, m_sorted_tag, m_final_result,   | one record in sorted order
//          |           | m_overflowed                                  |
//
// Insertion: records are sorted as they arrive by insertion into the store. Each
//   stored record with a larger key moves up one entry in turn, and the new record
//   then fills the hole left; a record into an empty store is written at once, and
//   one at a full store is dropped. The one comparator and the single store write
//   port shift one record at a time. After the last record, once ST_EMIT_RD has read
//   the first entry, the run is read out at one transaction per cycle while m_ready is high.
// Reset: aresetn is synchronous, active low; it empties the set and clears the
//   overflow flag. The store contents are not cleared; only written entries are read.
// Stalls: s_ready is high only while idle. The output register holds a result
//   under m_ready low; once the final result is loaded the block takes the next
//   set while that result still waits.
module record_sort_by_key
    import rsbk_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic             aclk,
    input  logic             aresetn,

    input  logic             s_valid,
    output logic             s_ready,
    input  logic [KEY_W-1:0] s_sort_key,
    input  logic [TAG_W-1:0] s_record_tag,
    input  logic             s_last_item,

    output logic             m_valid,
    input  logic             m_ready,
    output logic [KEY_W-1:0] m_sorted_key,
    output logic [TAG_W-1:0] m_sorted_tag,
    output logic             m_final_result,
    output logic             m_overflowed
);

    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    // Control state
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               ovf_reg, ovf_next;
    logic [ADDR_W-1:0]  j_reg, j_next;          // hole being filled during insertion
    logic [ADDR_W-1:0]  emit_idx_reg, emit_idx_next;
    logic               last_reg, last_next;
    logic               m_valid_reg, m_valid_next;

    // Payload
    record_t            hold_reg, hold_next;    // record being inserted
    record_t            out_rec_reg, out_rec_next;
    logic               out_final_reg, out_final_next;
    logic               out_ovf_reg, out_ovf_next;

    // Store port
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    record_t            wr_data;
    logic [ADDR_W-1:0]  rd_addr;
    record_t            rd_data;

    logic               s_accept;
    logic               full;
    logic               empty;
    logic               greater;
    logic               j_is_one;
    logic               emit_last;
    logic               out_load;
    record_t            in_rec;

    rsbk_ram #(
        .DEPTH  (CAPACITY),
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign in_rec   = '{key: s_sort_key, tag: s_record_tag};
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign empty    = (count_reg == '0);
    // the one shared comparator: strict compare keeps equal keys in arrival order
    assign greater  = (rd_data.key > hold_reg.key);
    assign j_is_one = (j_reg == ADDR_W'(1));
    assign emit_last = ((CNT_W'(emit_idx_reg) + CNT_W'(1)) == count_reg);
    assign out_load = (state_reg == ST_EMIT_LD) && (!m_valid_reg || m_ready);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (!full && !empty) begin
                        state_next = ST_SHIFT;
                    end else if (s_last_item) begin
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            ST_SHIFT: begin
                if (greater) begin
                    if (j_is_one) begin
                        state_next = ST_PLACE;
                    end
                end else begin
                    state_next = last_reg ? ST_EMIT_RD : ST_IDLE;
                end
            end
            ST_PLACE: begin
                state_next = last_reg ? ST_EMIT_RD : ST_IDLE;
            end
            ST_EMIT_RD: begin
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                if (out_load && emit_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and store control
    always_comb begin
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        j_next         = j_reg;
        emit_idx_next  = emit_idx_reg;
        last_next      = last_reg;
        hold_next      = hold_reg;
        out_rec_next   = out_rec_reg;
        out_final_next = out_final_reg;
        out_ovf_next   = out_ovf_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        wr_en          = 1'b0;
        wr_addr        = j_reg;
        wr_data        = hold_reg;
        rd_addr        = emit_idx_reg;

        case (state_reg)
            ST_IDLE: begin
                emit_idx_next = '0;
                // neighbour below the new slot, used when shifting starts
                rd_addr       = count_reg[ADDR_W-1:0] - ADDR_W'(1);
                if (s_accept) begin
                    hold_next = in_rec;
                    last_next = s_last_item;
                    if (full) begin
                        ovf_next = 1'b1;
                    end else begin
                        count_next = count_reg + CNT_W'(1);
                        j_next     = count_reg[ADDR_W-1:0];
                        if (empty) begin
                            wr_en   = 1'b1;
                            wr_addr = '0;
                            wr_data = in_rec;
                        end
                    end
                end
            end
            ST_SHIFT: begin
                rd_addr = (j_reg - ADDR_W'(1)) - ADDR_W'(1);
                wr_en   = 1'b1;
                wr_addr = j_reg;
                if (greater) begin
                    wr_data = rd_data;
                    j_next  = j_reg - ADDR_W'(1);
                end else begin
                    wr_data = hold_reg;
                end
            end
            ST_PLACE: begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = hold_reg;
            end
            ST_EMIT_RD: begin
                rd_addr = emit_idx_reg;
            end
            ST_EMIT_LD: begin
                if (out_load) begin
                    // fetch the next entry while this one goes out
                    rd_addr        = emit_idx_reg + ADDR_W'(1);
                    emit_idx_next  = emit_idx_reg + ADDR_W'(1);
                    out_rec_next   = rd_data;
                    out_final_next = emit_last;
                    out_ovf_next   = ovf_reg;
                    m_valid_next   = 1'b1;
                    if (emit_last) begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                    end
                end else begin
                    rd_addr = emit_idx_reg;
                end
            end
            default: begin
                rd_addr = emit_idx_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            j_reg        <= '0;
            emit_idx_reg <= '0;
            last_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            ovf_reg      <= ovf_next;
            j_reg        <= j_next;
            emit_idx_reg <= emit_idx_next;
            last_reg     <= last_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hold_reg      <= hold_next;
        out_rec_reg   <= out_rec_next;
        out_final_reg <= out_final_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_sorted_key   = out_rec_reg.key;
    assign m_sorted_tag   = out_rec_reg.tag;
    assign m_final_result = out_final_reg;
    assign m_overflowed   = out_ovf_reg;

    // Checks

    // the set never holds more than the store
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("record count beyond capacity");

    // a dropped record is only possible with a full store
    assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |-> full)
        else $error("overflow flagged with room left");

    // shifting never runs past entry 0
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SHIFT) |-> (j_reg != '0))
        else $error("insertion hole at entry 0 while shifting");

    // loading the final result empties the set and frees the input side
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && emit_last) |=> (state_reg == ST_IDLE) && empty && !ovf_reg
                                    && m_valid && m_final_result)
        else $error("run did not close after final result");

endmodule

// ----- sim/rsbk_sort_checker.sv -----
// Checker for the record sorter: predicts each sorted run and compares it on the m_ channel.
`timescale 1ns / 100ps

module rsbk_sort_checker
    import rsbk_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic             aclk,
    input  logic             aresetn,

    input  logic             s_valid,
    input  logic             s_ready,
    input  logic [KEY_W-1:0] s_sort_key,
    input  logic [TAG_W-1:0] s_record_tag,
    input  logic             s_last_item,

    input  logic             m_valid,
    input  logic             m_ready,
    input  logic [KEY_W-1:0] m_sorted_key,
    input  logic [TAG_W-1:0] m_sorted_tag,
    input  logic             m_final_result,
    input  logic             m_overflowed,

    output int               mismatches,
    output int               results_due
);

    typedef struct {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
        logic             final_flag;
        logic             ovf;
    } sorted_rec_t;

    record_t     held_records[$];
    logic        dropped_any = 1'b0;
    sorted_rec_t sorted_due_q[$];
    int          fail_total  = 0;

    task automatic note_failure(input string what);
        fail_total++;
        if (fail_total <= 10)
            $display("[%0t] %s", $realtime, what);
    endtask

    // Stable ascending order: take the smallest key left, earliest arrival on a tie.
    task automatic emit_sorted_run();
        record_t     pool[$];
        sorted_rec_t res;
        int          best;
        pool = held_records;
        while (pool.size() > 0) begin
            best = 0;
            for (int i = 1; i < pool.size(); i++)
                if (pool[i].key < pool[best].key)
                    best = i;
            res.key        = pool[best].key;
            res.tag        = pool[best].tag;
            res.final_flag = (pool.size() == 1);
            res.ovf        = dropped_any;
            sorted_due_q.push_back(res);
            pool.delete(best);
        end
        held_records.delete();
        dropped_any = 1'b0;
    endtask

    task automatic absorb_record(input logic [KEY_W-1:0] key, input logic [TAG_W-1:0] tag,
                                 input logic last);
        record_t rec;
        rec.key = key;
        rec.tag = tag;
        if (held_records.size() < CAPACITY)
            held_records.push_back(rec);
        else
            dropped_any = 1'b1;
        if (last)
            emit_sorted_run();
    endtask

    task automatic check_result();
        sorted_rec_t want;
        if (sorted_due_q.size() == 0) begin
            note_failure($sformatf("unexpected result: key %h tag %h final %b ovf %b",
                                   m_sorted_key, m_sorted_tag, m_final_result, m_overflowed));
            return;
        end
        want = sorted_due_q.pop_front();
        if (m_sorted_key !== want.key || m_sorted_tag !== want.tag ||
            m_final_result !== want.final_flag || m_overflowed !== want.ovf)
            note_failure($sformatf(
                "mismatch: exp key %h tag %h final %b ovf %b, got key %h tag %h final %b ovf %b",
                want.key, want.tag, want.final_flag, want.ovf,
                m_sorted_key, m_sorted_tag, m_final_result, m_overflowed));
    endtask

    // Results go first: a new set's run always queues behind anything still owed.
    always @(posedge aclk) begin
        if (!aresetn) begin
            held_records.delete();
            sorted_due_q.delete();
            dropped_any = 1'b0;
        end else begin
            if (m_valid && m_ready)
                check_result();
            if (s_valid && s_ready)
                absorb_record(s_sort_key, s_record_tag, s_last_item);
        end
        mismatches  <= fail_total;
        results_due <= sorted_due_q.size();
    end

endmodule

// ----- sim/tb_top.sv -----
// Testbench top for the record sorter: record stimulus, back-pressure and the verdict.
`timescale 1ns / 100ps

module tb_top;
    import rsbk_pkg::*;

    localparam int CAPACITY        = 64;
    localparam int ITEMS_PER_PHASE = 90;
    // time limit; a correct run needs well under a tenth of it even at worst-case
    // insertion cost per record and heavy stalling on both channels
    localparam int LIMIT_NS        = 1_000_000;

    // idling per phase, in cycles of a hundred: none, sender, receiver, both
    localparam int SRC_IDLE[4]  = '{0, 82, 0, 12};
    localparam int SNK_STALL[4] = '{0, 0, 82, 12};

    // how the keys of a set are drawn; the narrow style forces plenty of equal keys
    typedef enum int {
        KEYS_WIDE,
        KEYS_NARROW,
        KEYS_EXTREME
    } key_style_e;

    logic             aclk         = 1'b0;
    logic             aresetn      = 1'b0;
    logic             s_valid      = 1'b0;
    logic             s_ready;
    logic [KEY_W-1:0] s_sort_key   = '0;
    logic [TAG_W-1:0] s_record_tag = '0;
    logic             s_last_item  = 1'b0;
    logic             m_valid;
    logic             m_ready      = 1'b0;
    logic [KEY_W-1:0] m_sorted_key;
    logic [TAG_W-1:0] m_sorted_tag;
    logic             m_final_result;
    logic             m_overflowed;

    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    int phase_items   = 0;
    int checker_errors;
    int checker_pending;

    initial begin
        forever #1 aclk = ~aclk;
    end

    record_sort_by_key #(
        .CAPACITY (CAPACITY)
    ) u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sort_key     (s_sort_key),
        .s_record_tag   (s_record_tag),
        .s_last_item    (s_last_item),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sorted_key   (m_sorted_key),
        .m_sorted_tag   (m_sorted_tag),
        .m_final_result (m_final_result),
        .m_overflowed   (m_overflowed)
    );

    rsbk_sort_checker #(
        .CAPACITY (CAPACITY)
    ) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sort_key     (s_sort_key),
        .s_record_tag   (s_record_tag),
        .s_last_item    (s_last_item),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sorted_key   (m_sorted_key),
        .m_sorted_tag   (m_sorted_tag),
        .m_final_result (m_final_result),
        .m_overflowed   (m_overflowed),
        .mismatches     (checker_errors),
        .results_due    (checker_pending)
    );

    // Receiver: a fresh stall decision every cycle, so stalls land on every phase of
    // the read-out, including the final result that the block holds over a new set.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // One record transaction. Gaps come before valid is raised; once raised, valid and
    // the payload stay put until the handshake. Valid is left high on return so that
    // back-to-back records never see it dropped and raised in the same step.
    task automatic send_record(input logic [KEY_W-1:0] key, input logic [TAG_W-1:0] tag,
                               input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_sort_key   <= key;
        s_record_tag <= tag;
        s_last_item  <= last;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        phase_items++;
    endtask

    function automatic logic [KEY_W-1:0] pick_key(input key_style_e style);
        case (style)
            KEYS_WIDE:   return $urandom();
            KEYS_NARROW: return $urandom_range(3);
            default: begin
                case ($urandom_range(3))
                    0:       return '0;
                    1:       return '1;
                    2:       return {1'b1, {(KEY_W-1){1'b0}}};
                    default: return $urandom();
                endcase
            end
        endcase
    endfunction

    // Mostly small sets; a few at or just under capacity, a few that overrun it.
    function automatic int pick_set_size();
        int roll;
        roll = $urandom_range(99);
        if (roll < 70)
            return $urandom_range(8, 1);
        else if (roll < 85)
            return $urandom_range(32, 9);
        else if (roll < 95)
            return $urandom_range(CAPACITY, CAPACITY - 4);
        else
            return $urandom_range(CAPACITY + 4, CAPACITY + 1);
    endfunction

    task automatic send_set(input int n, input key_style_e style);
        for (int i = 0; i < n; i++)
            send_record(pick_key(style), TAG_W'($urandom_range(16'hFFFF)), i == n - 1);
    endtask

    // Sender holds off until every sorted result owed so far has been taken.
    // Always waits on a clock edge before the check, so valid is not lowered and raised in one step.
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        do
            @(posedge aclk);
        while (checker_pending != 0);
    endtask

    initial begin
        aresetn <= 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed sets
        // single-record set
        send_record(32'h0000_0000, 16'h0000, 1'b1);
        // extreme keys and tags, with a tie on the top key
        send_record(32'hFFFF_FFFF, 16'hFFFF, 1'b0);
        send_record(32'h0000_0000, 16'h0000, 1'b0);
        send_record(32'hFFFF_FFFF, 16'h1234, 1'b0);
        send_record(32'h8000_0000, 16'h8000, 1'b1);
        // descending keys: every record has to land in entry 0
        send_record(32'd50, 16'h0005, 1'b0);
        send_record(32'd40, 16'h0004, 1'b0);
        send_record(32'd30, 16'h0003, 1'b0);
        send_record(32'd20, 16'h0002, 1'b0);
        send_record(32'd10, 16'h0001, 1'b1);
        // already in order
        send_record(32'd1, 16'h00A1, 1'b0);
        send_record(32'd2, 16'h00A2, 1'b0);
        send_record(32'd3, 16'h00A3, 1'b0);
        send_record(32'd4, 16'h00A4, 1'b1);
        // all keys equal: arrival order must survive
        send_record(32'd7, 16'h0001, 1'b0);
        send_record(32'd7, 16'h0002, 1'b0);
        send_record(32'd7, 16'h0003, 1'b0);
        send_record(32'd7, 16'h0004, 1'b1);
        // two records swapped
        send_record(32'd1, 16'h5555, 1'b0);
        send_record(32'd0, 16'hAAAA, 1'b1);
        wait_for_drain();

        // Random sets, one idling pattern per phase; each phase ends with a full drain
        for (int ph = 0; ph < 4; ph++) begin
            src_idle_pct  = SRC_IDLE[ph];
            snk_stall_pct = SNK_STALL[ph];
            phase_items   = 0;
            // store fills, then the last record arrives with no room and is dropped
            if (ph == 0)
                send_set(CAPACITY + 1, KEYS_WIDE);
            while (phase_items < ITEMS_PER_PHASE)
                send_set(pick_set_size(), key_style_e'($urandom_range(KEYS_EXTREME)));
            wait_for_drain();
        end

        // nothing more is owed; a short tail catches stray results
        repeat (16) @(posedge aclk);
        if (checker_errors == 0 && checker_pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #(LIMIT_NS);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- files.f -----
design/rsbk_pkg.sv
design/rsbk_ram.sv
design/record_sort_by_key.sv
sim/rsbk_sort_checker.sv
sim/tb_top.sv
